>>> hw/rtl/dda_pkg.sv
// -----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared constants, codes and types for the line rasterizer.
// -----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int COORD_BITS_DEF = 12;

   localparam int          CANVAS_W     = 11;
   localparam logic [10:0] CANVAS_RESET = 11'd500;

   // request codes
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // register file
   localparam int   CSR_DATA_W     = 32;
   localparam int   CSR_ADDR_W     = 3;
   localparam logic CSR_IDX_CANVAS = 1'b0;

   // divider control from the sequencer
   typedef struct packed {
      logic go;    // load operands and start
      logic neg;   // quotient sign
   } div_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/dda_req_if.sv
// -----------------------------------------------------------------------------
// DDA request channel
// Valid/ready channel carrying start and tick transactions.
// -----------------------------------------------------------------------------
`default_nettype none

interface dda_req_if #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic signed [COORD_BITS-1:0] x_start;
   logic signed [COORD_BITS-1:0] y_start;
   logic signed [COORD_BITS-1:0] x_end;
   logic signed [COORD_BITS-1:0] y_end;
   logic                         mirror;
   logic signed [COORD_BITS-1:0] offset;

   modport source (
      output valid, req_type, x_start, y_start, x_end, y_end, mirror, offset,
      input  ready
   );
   modport sink (
      input  valid, req_type, x_start, y_start, x_end, y_end, mirror, offset,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/dda_rsp_if.sv
// -----------------------------------------------------------------------------
// DDA response channel
// Valid/ready channel carrying one pixel per transaction.
// -----------------------------------------------------------------------------
`default_nettype none

interface dda_rsp_if #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic signed [COORD_BITS:0] pixel_x;
   logic signed [COORD_BITS:0] pixel_y;
   logic                       inside_res;
   logic                       last;

   modport source (
      output valid, pixel_x, pixel_y, inside_res, last,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, inside_res, last,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/dda_div.sv
// -----------------------------------------------------------------------------
// DDA increment divider
// Restoring divider, one quotient bit per cycle: |d| * 2^FRAC_BITS / steps.
// -----------------------------------------------------------------------------
`default_nettype none

module dda_div #(
   parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  dda_pkg::div_ctl_type         ctl,
   input  wire         [COORD_BITS-1:0] num,   // |d|, never above den
   input  wire         [COORD_BITS-1:0] den,   // steps, nonzero
   output logic                         done,
   output logic signed [FRAC_BITS+1:0]  quot
);
   localparam int ITER  = FRAC_BITS + 1;   // integer bit plus fraction bits
   localparam int CNT_W = $clog2(ITER + 1);

   logic [COORD_BITS-1:0] rem_ff;
   logic [FRAC_BITS:0]    q_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  first_ff;
   logic                  neg_ff;
   logic                  done_ff;

   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   diff;
   logic                  fits;
   logic [FRAC_BITS+1:0]  mag;

   // first step compares the numerator itself (integer bit), then shift
   assign trial = first_ff ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign diff  = trial - {1'b0, den};
   assign fits  = (trial >= {1'b0, den});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (ctl.go) begin
         rem_ff   <= num;
         q_ff     <= '0;
         cnt_ff   <= CNT_W'(ITER);
         busy_ff  <= 1'b1;
         first_ff <= 1'b1;
         neg_ff   <= ctl.neg;
         done_ff  <= 1'b0;
      end else if (busy_ff) begin
         rem_ff   <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
         q_ff     <= {q_ff[FRAC_BITS-1:0], fits};
         first_ff <= 1'b0;
         cnt_ff   <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign mag  = {1'b0, q_ff};
   assign quot = neg_ff ? -mag : mag;
   assign done = done_ff;

endmodule

`default_nettype wire

>>> hw/rtl/dda_pix.sv
// -----------------------------------------------------------------------------
// DDA pixel mapper
// Mirror, offset and truncate one accumulator to a pixel; canvas range check.
// -----------------------------------------------------------------------------
`default_nettype none

module dda_pix #(
   parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
   input  wire  [COORD_BITS+FRAC_BITS:0]    acc,
   input  wire                              mirror,
   input  wire  [COORD_BITS-1:0]            offset,
   input  wire  [dda_pkg::CANVAS_W-1:0]     canvas,
   output logic [COORD_BITS:0]              pixel,
   output logic                             in_range
);
   localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
   localparam int V_W   = ACC_W + 1;
   localparam int Q_W   = COORD_BITS + 2;
   localparam int CMP_W = (Q_W > dda_pkg::CANVAS_W) ? Q_W : dda_pkg::CANVAS_W;

   logic [V_W-1:0]   acc_ext;
   logic [V_W-1:0]   mir;
   logic [V_W-1:0]   off_ext;
   logic [V_W-1:0]   v;
   logic             round_up;
   logic [Q_W-1:0]   q;

   assign acc_ext  = {acc[ACC_W-1], acc};
   assign mir      = mirror ? -acc_ext : acc_ext;
   assign off_ext  = {{(V_W-COORD_BITS-FRAC_BITS){offset[COORD_BITS-1]}},
                      offset, {FRAC_BITS{1'b0}}};
   assign v        = mir + off_ext;

   // arithmetic shift floors; bump negatives with a fraction toward zero
   assign round_up = v[V_W-1] & (|v[FRAC_BITS-1:0]);
   assign q        = v[V_W-1:FRAC_BITS] + Q_W'(round_up);

   assign pixel    = q[COORD_BITS:0];
   assign in_range = ~q[Q_W-1] && (CMP_W'(q) < CMP_W'(canvas));

endmodule

`default_nettype wire

>>> hw/rtl/dda_csr.sv
// -----------------------------------------------------------------------------
// DDA register file
// APB-style slave holding the canvas size register.
// -----------------------------------------------------------------------------
`default_nettype none

module dda_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire  [dda_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire  [dda_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dda_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic [dda_pkg::CANVAS_W-1:0]       canvas
);
   logic                          idx;
   logic                          wr_en;
   logic [dda_pkg::CANVAS_W-1:0]  canvas_ff;

   assign idx    = paddr[2];
   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_ff <= dda_pkg::CANVAS_RESET;
      end else if (wr_en && idx == dda_pkg::CSR_IDX_CANVAS) begin
         canvas_ff <= pwdata[dda_pkg::CANVAS_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (idx == dda_pkg::CSR_IDX_CANVAS) begin
         prdata = dda_pkg::CSR_DATA_W'(canvas_ff);
      end
   end

   assign canvas = canvas_ff;

endmodule

`default_nettype wire

>>> hw/rtl/dda_line_rasterizer_top.sv
// -----------------------------------------------------------------------------
// DDA line rasterizer top
// Start transactions set up a line; tick transactions emit one pixel each while a line is in progress.
// -----------------------------------------------------------------------------
// Setup: a start transaction of nonzero length keeps req.ready low while the
//   shared divider forms inc_x, then inc_y.
// Throughput: one tick per cycle; a pixel lands in the output register the
//   cycle after its tick and ticks keep flowing while the sink takes them.
// Reset (synchronous, active high): idle, no line in progress, output empty,
//   canvas size back to 500.
// -----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer_top #(
   parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
   parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   dda_req_if.sink                          req,
   dda_rsp_if.source                        rsp,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [dda_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [dda_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dda_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;  // fixed-point position
   localparam int INC_W = FRAC_BITS + 2;               // |inc| <= 1.0
   localparam int OUT_W = COORD_BITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

   state_type state_in, state_ff;

   // line state
   logic [ACC_W-1:0]       acc_x_ff, acc_y_ff;
   logic [INC_W-1:0]       inc_x_ff, inc_y_ff;
   logic [COORD_BITS-1:0]  remaining_ff;
   logic                   mirror_ff;
   logic [COORD_BITS-1:0]  offset_ff;
   logic [COORD_BITS-1:0]  abs_dx_ff, abs_dy_ff;
   logic                   neg_x_ff, neg_y_ff;
   logic                   go_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [OUT_W-1:0]       pixel_x_ff, pixel_y_ff;
   logic                   inside_ff;
   logic                   last_ff;

   // start decode
   logic [COORD_BITS:0]    dx, dy;
   logic [COORD_BITS-1:0]  abs_dx, abs_dy, steps;

   logic                   req_fire;
   logic                   start_fire;
   logic                   tick_fire;
   logic                   emit;

   dda_pkg::div_ctl_type   div_ctl;
   logic [COORD_BITS-1:0]  div_num;
   logic                   div_done;
   logic [INC_W-1:0]       div_quot;

   logic [OUT_W-1:0]       pix_x, pix_y;
   logic                   in_x, in_y;
   logic [dda_pkg::CANVAS_W-1:0] canvas;

   // ---------------------------------------------------------------- handshake
   // Output slot must be free (or draining) before any transaction is taken.
   assign req.ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_fire   = req.valid && req.ready;
   assign start_fire = req_fire && (req.req_type == dda_pkg::REQ_START);
   assign tick_fire  = req_fire && (req.req_type == dda_pkg::REQ_TICK);
   // a tick with no line in progress is dropped
   assign emit       = tick_fire && (remaining_ff != '0);

   // ---------------------------------------------------------------- setup math
   assign dx     = {req.x_end[COORD_BITS-1], req.x_end}
                 - {req.x_start[COORD_BITS-1], req.x_start};
   assign dy     = {req.y_end[COORD_BITS-1], req.y_end}
                 - {req.y_start[COORD_BITS-1], req.y_start};
   assign abs_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
   assign abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
   assign steps  = (abs_dx >= abs_dy) ? abs_dx : abs_dy;

   // ---------------------------------------------------------------- divider
   // One divider serves both axes: x first, then y. Divisor is the step
   // count, which remaining_ff still holds during setup.
   assign div_ctl.go  = go_ff;
   assign div_ctl.neg = (state_ff == ST_DIV_X) ? neg_x_ff : neg_y_ff;
   assign div_num     = (state_ff == ST_DIV_X) ? abs_dx_ff : abs_dy_ff;

   dda_div #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (remaining_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_fire && steps != '0) state_in = ST_DIV_X;
         end
         ST_DIV_X: begin
            if (div_done) state_in = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            if (div_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remaining_ff <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= (start_fire && steps != '0) ||
                     (state_ff == ST_DIV_X && div_done);

         if (start_fire) begin
            // a new line abandons any line in progress
            remaining_ff <= steps;
         end else if (emit) begin
            remaining_ff <= remaining_ff - 1'b1;
         end

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (start_fire) begin
         acc_x_ff  <= {req.x_start[COORD_BITS-1], req.x_start, {FRAC_BITS{1'b0}}};
         acc_y_ff  <= {req.y_start[COORD_BITS-1], req.y_start, {FRAC_BITS{1'b0}}};
         inc_x_ff  <= '0;
         inc_y_ff  <= '0;
         mirror_ff <= req.mirror;
         offset_ff <= req.offset;
         abs_dx_ff <= abs_dx;
         abs_dy_ff <= abs_dy;
         neg_x_ff  <= dx[COORD_BITS];
         neg_y_ff  <= dy[COORD_BITS];
      end else if (emit) begin
         acc_x_ff <= acc_x_ff + {{(ACC_W-INC_W){inc_x_ff[INC_W-1]}}, inc_x_ff};
         acc_y_ff <= acc_y_ff + {{(ACC_W-INC_W){inc_y_ff[INC_W-1]}}, inc_y_ff};
      end

      if (div_done && state_ff == ST_DIV_X) inc_x_ff <= div_quot;
      if (div_done && state_ff == ST_DIV_Y) inc_y_ff <= div_quot;

      if (emit) begin
         pixel_x_ff <= pix_x;
         pixel_y_ff <= pix_y;
         inside_ff  <= in_x & in_y;
         last_ff    <= (remaining_ff == COORD_BITS'(1));
      end
   end

   // pixel mapping per axis, from the accumulator before it advances
   dda_pix #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_pix_x (
      .acc      (acc_x_ff),
      .mirror   (mirror_ff),
      .offset   (offset_ff),
      .canvas   (canvas),
      .pixel    (pix_x),
      .in_range (in_x)
   );

   dda_pix #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_pix_y (
      .acc      (acc_y_ff),
      .mirror   (mirror_ff),
      .offset   (offset_ff),
      .canvas   (canvas),
      .pixel    (pix_y),
      .in_range (in_y)
   );

   // ---------------------------------------------------------------- registers
   dda_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .canvas  (canvas)
   );

   // ---------------------------------------------------------------- outputs
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pixel_x    = pixel_x_ff;
   assign rsp.pixel_y    = pixel_y_ff;
   assign rsp.inside_res = inside_ff;
   assign rsp.last       = last_ff;

   // ---------------------------------------------------------------- checks
   // divider finishes only while the sequencer waits for it
   a_done_in_setup: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_X || state_ff == ST_DIV_Y))
      else $error("divider done outside setup");

   // a zero-length line leaves the block idle with nothing to draw
   a_zero_line: assert property (@(posedge clock) disable iff (reset)
      (start_fire && steps == '0) |=> (state_ff == ST_IDLE && remaining_ff == '0))
      else $error("zero-length line not idle");

   // the pixel flagged last empties the line
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (emit && remaining_ff == COORD_BITS'(1)) |=> (remaining_ff == '0 && last_ff))
      else $error("last pixel did not end the line");

endmodule

`default_nettype wire

>>> sim/dda_line_rasterizer_top_test.sv
// -----------------------------------------------------------------------------
// DDA line rasterizer testbench
// Drives start and tick transactions into the rasterizer, predicts every pixel
// with a fixed-point line stepper of its own and checks each pixel transaction
// field by field. Canvas size is rewritten between phases that vary idling.
// -----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer_top_test;

   localparam int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF;
   localparam int COORD_BITS = dda_pkg::COORD_BITS_DEF;
   localparam int CANVAS_W   = dda_pkg::CANVAS_W;
   localparam int CSR_ADDR_W = dda_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = dda_pkg::CSR_DATA_W;
   localparam int ACC_W      = COORD_BITS + FRAC_BITS + 1;   // fixed-point position
   localparam int INC_W      = FRAC_BITS + 2;                // per-pixel step
   localparam longint ONE    = longint'(1) << FRAC_BITS;

   localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
   localparam int CANVAS_MAX = (1 << CANVAS_W) - 1;

   // start transactions hold ready low while the divider runs
   localparam int DRAIN_CYCLES    = 2 * FRAC_BITS + 32;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int NUM_PHASES      = 6;
   localparam int MAX_TICKS       = 48;
   localparam int CYCLE_LIMIT     = 500000;

   localparam logic [CSR_ADDR_W-1:0] CANVAS_ADDR =
      CSR_ADDR_W'(4 * dda_pkg::CSR_IDX_CANVAS);

   typedef struct packed {
      logic                         req_type;
      logic signed [COORD_BITS-1:0] x_start;
      logic signed [COORD_BITS-1:0] y_start;
      logic signed [COORD_BITS-1:0] x_end;
      logic signed [COORD_BITS-1:0] y_end;
      logic                         mirror;
      logic signed [COORD_BITS-1:0] offset;
   } line_req_type;

   typedef struct packed {
      logic signed [COORD_BITS:0] x;
      logic signed [COORD_BITS:0] y;
      logic                       in_canvas;
      logic                       last;
   } pixel_type;

   // --------------------------------------------------------------------------
   // Pixel scoreboard: steps its own copy of the line state on every accepted
   // request and queues the pixel each live tick must produce.
   // --------------------------------------------------------------------------
   class dda_pixel_scoreboard;
      logic signed [ACC_W-1:0]      acc_x, acc_y;
      logic signed [INC_W-1:0]      inc_x, inc_y;
      logic [COORD_BITS:0]          remaining;
      logic                         mirror_held;
      logic signed [COORD_BITS-1:0] offset_held;
      int                           canvas;
      pixel_type                    expected_pixels[$];
      int                           mismatches;

      function new();
         acc_x       = '0;
         acc_y       = '0;
         inc_x       = '0;
         inc_y       = '0;
         remaining   = '0;
         mirror_held = 1'b0;
         offset_held = '0;
         canvas      = int'(dda_pkg::CANVAS_RESET);
         mismatches  = 0;
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("%s", what);
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // mirror, add offset, drop fraction (toward zero)
      function longint pixel_of(logic signed [ACC_W-1:0] acc);
         longint v;
         v = mirror_held ? -longint'(acc) : longint'(acc);
         v = v + longint'(offset_held) * ONE;
         return v / ONE;
      endfunction

      function void note_request(line_req_type r);
         longint    x1, y1, dx, dy, ax, ay, steps, px, py;
         pixel_type p;
         if (r.req_type == dda_pkg::REQ_START) begin
            x1 = longint'($signed(r.x_start));
            y1 = longint'($signed(r.y_start));
            dx = longint'($signed(r.x_end)) - x1;
            dy = longint'($signed(r.y_end)) - y1;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            steps = (ax >= ay) ? ax : ay;
            mirror_held = r.mirror;
            offset_held = r.offset;
            acc_x = ACC_W'(x1 * ONE);
            acc_y = ACC_W'(y1 * ONE);
            if (steps == 0) begin
               // zero-length line: nothing will ever be drawn
               inc_x     = '0;
               inc_y     = '0;
               remaining = '0;
            end else begin
               inc_x     = INC_W'((dx * ONE) / steps);
               inc_y     = INC_W'((dy * ONE) / steps);
               remaining = (COORD_BITS + 1)'(steps);
            end
         end else if (remaining != 0) begin
            px = pixel_of(acc_x);
            py = pixel_of(acc_y);
            p.x         = px[COORD_BITS:0];
            p.y         = py[COORD_BITS:0];
            p.in_canvas = (px >= 0) && (px < canvas) && (py >= 0) && (py < canvas);
            p.last      = (remaining == 1);
            expected_pixels = {expected_pixels, p};
            acc_x     = acc_x + inc_x;
            acc_y     = acc_y + inc_y;
            remaining = remaining - 1'b1;
         end
         // tick with no line in progress: ignored
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            flag($sformatf("unexpected pixel x=%0d y=%0d inside=%0b last=%0b",
                           got.x, got.y, got.in_canvas, got.last));
            return;
         end
         want = expected_pixels.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.in_canvas !== want.in_canvas ||
             got.last !== want.last)
            flag($sformatf({"pixel mismatch: expected x=%0d y=%0d inside=%0b last=%0b,",
                            " got x=%0d y=%0d inside=%0b last=%0b"},
                           want.x, want.y, want.in_canvas, want.last,
                           got.x, got.y, got.in_canvas, got.last));
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // DUT and its channels
   // --------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dda_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   dda_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   dda_line_rasterizer_top #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dda_pixel_scoreboard sb = new();

   // idling knobs, percent per cycle; changed only between phases
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int cycle_count   = 0;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side back-pressure, re-rolled every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor: both channels sampled at the same edge the DUT sees them.
   // A pixel always belongs to a tick from an earlier edge, so checking it
   // before noting this edge's request keeps the queue order right.
   always @(posedge clock) begin
      pixel_type    got;
      line_req_type seen;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.x         = rsp_bus.pixel_x;
            got.y         = rsp_bus.pixel_y;
            got.in_canvas = rsp_bus.inside_res;
            got.last      = rsp_bus.last;
            sb.check_pixel(got);
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.req_type = req_bus.req_type;
            seen.x_start  = req_bus.x_start;
            seen.y_start  = req_bus.y_start;
            seen.x_end    = req_bus.x_end;
            seen.y_end    = req_bus.y_end;
            seen.mirror   = req_bus.mirror;
            seen.offset   = req_bus.offset;
            sb.note_request(seen);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------------

   // Optional idle cycles after a transaction; valid drops once per step.
   task automatic sender_gap();
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Present one request and hold it until the DUT takes it.
   task automatic send_request(line_req_type r);
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= r.req_type;
      req_bus.x_start  <= r.x_start;
      req_bus.y_start  <= r.y_start;
      req_bus.x_end    <= r.x_end;
      req_bus.y_end    <= r.y_end;
      req_bus.mirror   <= r.mirror;
      req_bus.offset   <= r.offset;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sender_gap();
   endtask

   // Every field but the type random; ticks carry junk endpoints that must be ignored.
   function automatic line_req_type tick_req();
      line_req_type r;
      r.req_type = dda_pkg::REQ_TICK;
      r.x_start  = COORD_BITS'($urandom);
      r.y_start  = COORD_BITS'($urandom);
      r.x_end    = COORD_BITS'($urandom);
      r.y_end    = COORD_BITS'($urandom);
      r.mirror   = 1'($urandom);
      r.offset   = COORD_BITS'($urandom);
      return r;
   endfunction

   function automatic line_req_type start_req(int x1, int y1, int x2, int y2,
                                              logic mir, int ofs);
      line_req_type r;
      r.req_type = dda_pkg::REQ_START;
      r.x_start  = COORD_BITS'(x1);
      r.y_start  = COORD_BITS'(y1);
      r.x_end    = COORD_BITS'(x2);
      r.y_end    = COORD_BITS'(y2);
      r.mirror   = mir;
      r.offset   = COORD_BITS'(ofs);
      return r;
   endfunction

   function automatic int clamp_coord(int v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic int abs_int(int v);
      return (v < 0) ? -v : v;
   endfunction

   // Stop sending, let every pixel drain, then give the divider time to
   // finish any start that produces no pixel.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // Register port (setup + access, pready honored though always high)
   // --------------------------------------------------------------------------
   task automatic csr_access(logic wr, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_canvas_readback();
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, CANVAS_ADDR, '0, rdata);
      if (rdata[CANVAS_W-1:0] !== CANVAS_W'(sb.canvas))
         sb.flag($sformatf("canvas readback: expected %0d, got %0d",
                           sb.canvas, rdata[CANVAS_W-1:0]));
   endtask

   task automatic set_canvas(int size);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b1, CANVAS_ADDR, CSR_DATA_W'(size), rdata);
      sb.canvas = size;
      check_canvas_readback();
   endtask

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin
      int           phase;
      int           counted;
      int           sel;
      int           span;
      int           x1, y1, x2, y2;
      int           steps;
      int           ticks;
      int           canvas_plan [NUM_PHASES];
      line_req_type r;

      // known values everywhere from time zero
      reset            = 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= dda_pkg::REQ_START;
      req_bus.x_start  <= '0;
      req_bus.y_start  <= '0;
      req_bus.x_end    <= '0;
      req_bus.y_end    <= '0;
      req_bus.mirror   <= 1'b0;
      req_bus.offset   <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the canvas register
      check_canvas_readback();

      // ---- directed: canvas at its reset size, no idling ----
      // tick with no line in progress
      send_request(tick_req());
      // zero-length line, then a tick that must be ignored
      send_request(start_req(5, -7, 5, -7, 1'b0, 0));
      send_request(tick_req());
      // corner to corner, largest offset; abandoned after two pixels
      send_request(start_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, COORD_MAX));
      send_request(tick_req());
      send_request(tick_req());
      // opposite diagonal, mirrored, most negative offset; abandons the one above
      send_request(start_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1, COORD_MIN));
      send_request(tick_req());
      send_request(tick_req());
      // short mirrored line run past its end
      send_request(start_req(0, 0, 3, -2, 1'b1, 0));
      repeat (4) send_request(tick_req());
      // steep line with a negative fractional x: truncation toward zero
      send_request(start_req(0, 0, -1, 5, 1'b0, 5));
      repeat (5) send_request(tick_req());
      // mirrored negative fraction with offset landing around the canvas edge
      send_request(start_req(-2, 3, 1, 0, 1'b1, 499));
      repeat (3) send_request(tick_req());

      // ---- random phases: canvas extremes and idling patterns ----
      canvas_plan[0] = CANVAS_MAX;
      canvas_plan[1] = 0;                         // nothing can be inside
      canvas_plan[2] = 1;
      canvas_plan[3] = $urandom_range(CANVAS_MAX, 1);
      canvas_plan[4] = $urandom_range(64, 1);
      canvas_plan[5] = int'(dda_pkg::CANVAS_RESET);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_drain();
         set_canvas(canvas_plan[phase]);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 9; stall_pct = 9; end
         endcase

         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            r = tick_req();
            r.req_type = dda_pkg::REQ_START;
            x1 = int'($signed(r.x_start));
            y1 = int'($signed(r.y_start));
            sel = $urandom_range(19);
            if (sel == 0) begin
               x2 = x1;                           // zero length
               y2 = y1;
            end else if (sel == 1) begin
               x2 = int'($signed(r.x_end));       // long line, fully random
               y2 = int'($signed(r.y_end));
            end else begin
               span = $urandom_range(24, 1);
               x2 = clamp_coord(x1 + int'($urandom_range(2 * span)) - span);
               y2 = clamp_coord(y1 + int'($urandom_range(2 * span)) - span);
            end
            r.x_end = COORD_BITS'(x2);
            r.y_end = COORD_BITS'(y2);
            steps = (abs_int(x2 - x1) >= abs_int(y2 - y1)) ? abs_int(x2 - x1)
                                                            : abs_int(y2 - y1);
            send_request(r);
            counted++;

            // usually the whole line, sometimes cut short or run past the end
            if (steps + 2 > MAX_TICKS) ticks = $urandom_range(MAX_TICKS);
            else if ($urandom_range(3) == 0) ticks = $urandom_range(steps + 2);
            else ticks = steps;
            for (int k = 0; k < ticks; k++) begin
               send_request(tick_req());
               if (k < steps) counted++;
            end
         end
      end

      // ---- wind down ----
      send_idle_pct = 0;
      stall_pct     = 0;
      wait_for_drain();

      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
